@@ design/tcw_pkg.sv @@
// Package for the text console writer: geometry constants, command and
// character codes, controller states and the controller/datapath structs.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 16;

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST_A = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_FIRST_A = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST_A = ADDR_W'(CELL_COUNT - 1);

    localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
    localparam logic [7:0] ROW_LIM  = 8'(ROWS);
    localparam logic [7:0] COL_LAST = 8'(COLUMNS - 1);
    localparam logic [6:0] ROW_LAST = 7'(ROWS - 1);

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_EOF       = 8'd4;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] COLOR_RESET  = 8'h07;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CK_PRINT,
        CK_NEWLINE,
        CK_BACKSPACE,
        CK_EOF
    } t_char_kind;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_INC,
        CUR_HOME,
        CUR_SET
    } t_cur_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR_CUR,
        WR_BLANK_CUR,
        WR_BLANK_PTR
    } t_wr_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_WRITE,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        t_cur_op cur_op;
        t_wr_op  wr_op;
        logic    copy_step;
        logic    ptr_load;
        logic    ptr_fill_start;
        logic    mark_scroll;
        logic    cell_capture;
        logic    out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd       cmd;
        t_char_kind kind;
        logic       c_last;
        logic       r_last;
        logic       c_zero;
        logic       in_range;
        logic       copy_last;
        logic       fill_last;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/tcw_if.sv @@
// Channel interfaces of the text console writer: command in, result out,
// colour register write. Depends on tcw_pkg.
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [6:0] row;
    modport source (output valid, output cmd, output char_code, output col, output row,
                    input ready);
    modport sink   (input valid, input cmd, input char_code, input col, input row,
                    output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] cursor_col;
    logic [6:0] cursor_row;
    logic       did_scroll;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    modport source (output valid, output cursor_col, output cursor_row, output did_scroll,
                    output cell_char, output cell_attr, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row, input did_scroll,
                    input cell_char, input cell_attr, output ready);
endinterface

interface tcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/tcw_ctrl.sv @@
// Controller of the text console writer: sequences each command as steps
// of the datapath. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_ctrl_cmd       o_cmd
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{accept: 1'b0, cur_op: CUR_HOLD, wr_op: WR_NONE, copy_step: 1'b0,
                       ptr_load: 1'b0, ptr_fill_start: 1'b0, mark_scroll: 1'b0,
                       cell_capture: 1'b0, out_load: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.cmd)
                    CMD_WRITE: begin
                        case (i_status.kind)
                            CK_NEWLINE: begin
                                o_cmd.cur_op = CUR_NEWLINE;
                                if (i_status.r_last) begin
                                    o_cmd.mark_scroll = 1'b1;
                                    o_cmd.ptr_load    = 1'b1;
                                    n_state           = S_COPY;
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                            CK_BACKSPACE: begin
                                if (!i_status.c_zero) begin
                                    o_cmd.cur_op = CUR_BACK;
                                    n_state      = S_WRITE;
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                            CK_EOF: begin
                                n_state = S_DONE;
                            end
                            default: begin
                                if (i_status.c_last) begin
                                    o_cmd.cur_op = CUR_NEWLINE;
                                    if (i_status.r_last) begin
                                        o_cmd.mark_scroll = 1'b1;
                                        o_cmd.ptr_load    = 1'b1;
                                        n_state           = S_COPY;
                                    end else begin
                                        n_state = S_WRITE;
                                    end
                                end else begin
                                    n_state = S_WRITE;
                                end
                            end
                        endcase
                    end
                    CMD_CLEAR: begin
                        o_cmd.cur_op   = CUR_HOME;
                        o_cmd.ptr_load = 1'b1;
                        n_state        = S_FILL;
                    end
                    CMD_SET: begin
                        if (i_status.in_range) begin
                            o_cmd.cur_op = CUR_SET;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = i_status.in_range ? S_READ : S_DONE;
                    end
                endcase
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.ptr_load       = 1'b1;
                o_cmd.ptr_fill_start = 1'b1;
                n_state              = S_FILL;
            end
            S_FILL: begin
                o_cmd.wr_op = WR_BLANK_PTR;
                if (i_status.fill_last) begin
                    if (i_status.cmd == CMD_CLEAR || i_status.kind == CK_NEWLINE) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (i_status.kind == CK_BACKSPACE) begin
                    o_cmd.wr_op = WR_BLANK_CUR;
                end else begin
                    o_cmd.wr_op  = WR_CHAR_CUR;
                    o_cmd.cur_op = CUR_INC;
                end
                n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.cell_capture = 1'b1;
                n_state            = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/tcw_datapath.sv @@
// Datapath of the text console writer: command latch, cursor, colour,
// sweep pointer, screen RAM and result register. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tcw_pkg::t_ctrl_cmd  i_cmd,
    output tcw_pkg::t_dp_status      o_status,
    input  wire logic [1:0]          i_in_cmd,
    input  wire logic [7:0]          i_in_char,
    input  wire logic [7:0]          i_in_col,
    input  wire logic [6:0]          i_in_row,
    input  wire logic                i_cfg_valid,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [7:0]               o_cursor_col,
    output logic [6:0]               o_cursor_row,
    output logic                     o_did_scroll,
    output logic [7:0]               o_cell_char,
    output logic [7:0]               o_cell_attr
);
    import tcw_pkg::*;

    t_cmd              r_cmd;
    logic [7:0]        r_char;
    logic [7:0]        r_col_in;
    logic [6:0]        r_row_in;
    logic [7:0]        r_color;
    logic [7:0]        r_cur_col;
    logic [6:0]        r_cur_row;
    logic [7:0]        n_cur_col;
    logic [6:0]        n_cur_row;
    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] r_cp_dst;
    logic              r_cp_valid;
    logic              r_scrolled;
    logic [CELL_W-1:0] r_cell;
    logic              r_out_valid;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic              ram_we;
    t_char_kind        kind;

    assign cur_addr  = ADDR_W'(r_cur_row) * COLS_A + ADDR_W'(r_cur_col);
    assign cell_addr = ADDR_W'(r_row_in) * COLS_A + ADDR_W'(r_col_in);
    assign ram_raddr = i_cmd.copy_step ? r_ptr + COLS_A : cell_addr;

    always_comb begin
        case (r_char)
            CH_NEWLINE:   kind = CK_NEWLINE;
            CH_BACKSPACE: kind = CK_BACKSPACE;
            CH_EOF:       kind = CK_EOF;
            default:      kind = CK_PRINT;
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {r_color, CH_BLANK};
        case (i_cmd.wr_op)
            WR_CHAR_CUR: begin
                ram_wdata = {r_color, r_char};
            end
            WR_BLANK_CUR: begin
                ram_wdata = {r_color, CH_BLANK};
            end
            WR_BLANK_PTR: begin
                ram_waddr = r_ptr;
            end
            default: begin
                ram_we    = r_cp_valid;
                ram_waddr = r_cp_dst;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        case (i_cmd.cur_op)
            CUR_NEWLINE: begin
                n_cur_col = '0;
                if (r_cur_row != ROW_LAST) begin
                    n_cur_row = r_cur_row + 7'd1;
                end
            end
            CUR_BACK: n_cur_col = r_cur_col - 8'd1;
            CUR_INC:  n_cur_col = r_cur_col + 8'd1;
            CUR_HOME: begin
                n_cur_col = '0;
                n_cur_row = '0;
            end
            CUR_SET: begin
                n_cur_col = r_col_in;
                n_cur_row = r_row_in;
            end
            default: begin
                n_cur_col = r_cur_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= COLOR_RESET;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_cp_valid <= i_cmd.copy_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= t_cmd'(i_in_cmd);
            r_char     <= i_in_char;
            r_col_in   <= i_in_col;
            r_row_in   <= i_in_row;
            r_scrolled <= 1'b0;
            r_cell     <= '0;
        end else begin
            if (i_cmd.mark_scroll) begin
                r_scrolled <= 1'b1;
            end
            if (i_cmd.cell_capture) begin
                r_cell <= ram_rdata;
            end
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= i_cmd.ptr_fill_start ? FILL_FIRST_A : '0;
        end else if (i_cmd.copy_step || i_cmd.wr_op == WR_BLANK_PTR) begin
            r_ptr <= r_ptr + ADDR_W'(1);
        end
        if (i_cmd.copy_step) begin
            r_cp_dst <= r_ptr;
        end
        if (i_cmd.out_load) begin
            o_cursor_col <= r_cur_col;
            o_cursor_row <= r_cur_row;
            o_did_scroll <= r_scrolled;
            o_cell_char  <= r_cell[7:0];
            o_cell_attr  <= r_cell[15:8];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.cmd       = r_cmd;
    assign o_status.kind      = kind;
    assign o_status.c_last    = (r_cur_col == COL_LAST);
    assign o_status.r_last    = (r_cur_row == ROW_LAST);
    assign o_status.c_zero    = (r_cur_col == '0);
    assign o_status.in_range  = ({1'b0, r_col_in} < COL_LIM) && ({1'b0, r_row_in} < ROW_LIM);
    assign o_status.copy_last = (r_ptr == COPY_LAST_A);
    assign o_status.fill_last = (r_ptr == CELL_LAST_A);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

@@ design/text_console_writer.sv @@
// Top level of the text console writer: controller, datapath and channel
// wiring. Depends on tcw_pkg, tcw_if, tcw_ctrl, tcw_datapath.
//
//  Channel    Dir  Handshake     Payload
//  i_cmd_ch   in   valid/ready   cmd, char_code, col, row
//  o_res_ch   out  valid/ready   cursor_col, cursor_row, did_scroll, cell_char, cell_attr
//  i_cfg_ch   in   valid/ready   data (text colour), always ready
//
// One command at a time. A scroll copies ROWS-1 rows up through the single
// RAM read port, then writes a blank row; clear fills every cell with blanks.
// The result register lets the next command in while a result waits; a
// stalled result holds the controller before the following result.
// Synchronous active-low reset; the screen RAM is not cleared.
`default_nettype none

module text_console_writer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_cmd_ch,
    tcw_out_if.source o_res_ch,
    tcw_cfg_if.sink   i_cfg_ch
);
    import tcw_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    tcw_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_status     (dp_status),
        .i_in_cmd     (i_cmd_ch.cmd),
        .i_in_char    (i_cmd_ch.char_code),
        .i_in_col     (i_cmd_ch.col),
        .i_in_row     (i_cmd_ch.row),
        .i_cfg_valid  (i_cfg_ch.valid),
        .i_cfg_data   (i_cfg_ch.data),
        .i_out_ready  (o_res_ch.ready),
        .o_out_valid  (o_res_ch.valid),
        .o_cursor_col (o_res_ch.cursor_col),
        .o_cursor_row (o_res_ch.cursor_row),
        .o_did_scroll (o_res_ch.did_scroll),
        .o_cell_char  (o_res_ch.cell_char),
        .o_cell_attr  (o_res_ch.cell_attr)
    );

    assign i_cmd_ch.ready = in_ready;
    assign i_cfg_ch.ready = 1'b1;

endmodule

`default_nettype wire

@@ design/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module tcw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_cursor_col,
    input wire logic [6:0] i_cursor_row,
    input wire logic       i_did_scroll,
    input wire logic [7:0] i_cell_char,
    input wire logic [7:0] i_cell_attr
);
    import tcw_pkg::*;

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_cursor_col} < COL_LIM) && ({1'b0, i_cursor_row} < ROW_LIM))
        else $error("cursor outside the screen");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second transaction taken while busy");

    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_did_scroll) |-> (i_cell_char == 8'd0 && i_cell_attr == 8'd0))
        else $error("scrolled result carries cell data");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_cursor_col)
            && $stable(i_cursor_row) && $stable(i_did_scroll)
            && $stable(i_cell_char) && $stable(i_cell_attr))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd_ch.valid),
    .i_in_ready   (i_cmd_ch.ready),
    .i_out_valid  (o_res_ch.valid),
    .i_out_ready  (o_res_ch.ready),
    .i_cursor_col (o_res_ch.cursor_col),
    .i_cursor_row (o_res_ch.cursor_row),
    .i_did_scroll (o_res_ch.did_scroll),
    .i_cell_char  (o_res_ch.cell_char),
    .i_cell_attr  (o_res_ch.cell_attr)
);

`default_nettype wire
